>>> design/hrb_pkg.sv
`default_nettype none

package hrb_pkg;

   localparam int MAX_DATA_DEFAULT = 32;
   localparam int DESC_DEPTH = 4;

   localparam logic [7:0] TYPE_DATA    = 8'h00;
   localparam logic [7:0] TYPE_SEGMENT = 8'h02;
   localparam logic [7:0] TYPE_LINEAR  = 8'h04;

   localparam logic [1:0] STATUS_DATA     = 2'd0;
   localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
   localparam logic [1:0] STATUS_LENGTH   = 2'd2;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] address;
      logic [7:0]  length;
      logic        segment_start;
   } desc_type;

endpackage

`default_nettype wire

>>> design/hrb_queue.sv
`default_nettype none

module hrb_queue import hrb_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire desc_type push_desc,
   output logic          full,
   input  wire logic     pop,
   output logic          empty,
   output desc_type      head
);

   localparam int QAW = $clog2(DESC_DEPTH);

   desc_type entry_ff [DESC_DEPTH];
   logic [QAW:0] wr_ptr_ff;
   logic [QAW:0] rd_ptr_ff;

   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign full  = (wr_ptr_ff[QAW] != rd_ptr_ff[QAW]) &&
                  (wr_ptr_ff[QAW-1:0] == rd_ptr_ff[QAW-1:0]);
   assign head  = entry_ff[rd_ptr_ff[QAW-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff[QAW-1:0]] <= push_desc;
      end
   end

endmodule

`default_nettype wire

>>> design/hrb_front.sv
`default_nettype none

module hrb_front import hrb_pkg::*; #(
   parameter int MAX_DATA = MAX_DATA_DEFAULT,
   localparam int RING_AW = $clog2(2 * MAX_DATA)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_record_start,
   input  wire logic [7:0]         req_byte_value,
   output logic                    ring_wr_en,
   output logic [RING_AW-1:0]      ring_wr_addr,
   output logic [7:0]              ring_wr_data,
   input  wire logic [RING_AW:0]   ring_rd_ptr,
   output logic                    push,
   output desc_type                push_desc,
   input  wire logic               queue_full
);

   localparam int POS_W = $clog2(MAX_DATA + 5);
   localparam int LEN_W = $clog2(MAX_DATA + 1);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [15:0]       offset_ff, offset_in;
   logic [7:0]        type_ff, type_in;
   logic [7:0]        sum_ff, sum_in;
   logic [7:0]        pair_hi_ff, pair_hi_in;
   logic [7:0]        pair_lo_ff, pair_lo_in;
   logic [31:0]       base_ff, base_in;
   logic [32:0]       next_addr_ff, next_addr_in;
   logic              next_valid_ff, next_valid_in;
   logic              halted_ff, halted_in;
   logic [RING_AW:0]  wr_spec_ff, wr_spec_in;
   logic [RING_AW:0]  wr_commit_ff, wr_commit_in;

   logic              ring_full;
   logic              accept;
   logic [32:0]       start_addr;
   logic [7:0]        check_sum;

   assign ring_full = (wr_spec_ff[RING_AW] != ring_rd_ptr[RING_AW]) &&
                      (wr_spec_ff[RING_AW-1:0] == ring_rd_ptr[RING_AW-1:0]);
   assign req_stall = ring_full || queue_full;
   assign accept = req_valid && !req_stall;
   assign start_addr = {1'b0, base_ff} + {17'b0, offset_ff};
   assign check_sum = sum_ff + req_byte_value;

   always_comb begin
      pos_in        = pos_ff;
      len_in        = len_ff;
      offset_in     = offset_ff;
      type_in       = type_ff;
      sum_in        = sum_ff;
      pair_hi_in    = pair_hi_ff;
      pair_lo_in    = pair_lo_ff;
      base_in       = base_ff;
      next_addr_in  = next_addr_ff;
      next_valid_in = next_valid_ff;
      halted_in     = halted_ff;
      wr_spec_in    = wr_spec_ff;
      wr_commit_in  = wr_commit_ff;
      push          = 1'b0;
      push_desc     = '0;
      ring_wr_en    = 1'b0;
      ring_wr_addr  = wr_spec_ff[RING_AW-1:0];
      ring_wr_data  = req_byte_value;

      if (accept && !halted_ff) begin
         if (req_record_start) begin
            wr_spec_in = wr_commit_ff;
            if (req_byte_value > 8'(MAX_DATA)) begin
               push             = 1'b1;
               push_desc.status = STATUS_LENGTH;
               halted_in        = 1'b1;
               pos_in           = '0;
            end else begin
               len_in     = req_byte_value[LEN_W-1:0];
               sum_in     = req_byte_value;
               offset_in  = '0;
               type_in    = '0;
               pair_hi_in = '0;
               pair_lo_in = '0;
               pos_in     = POS_W'(1);
            end
         end else if (pos_ff == '0) begin
            pos_in = '0;
         end else if (pos_ff == POS_W'(len_ff) + POS_W'(4)) begin
            pos_in     = '0;
            wr_spec_in = wr_commit_ff;
            if (check_sum != 8'h00) begin
               push             = 1'b1;
               push_desc.status = STATUS_CHECKSUM;
               halted_in        = 1'b1;
            end else begin
               case (type_ff)
                  TYPE_SEGMENT: begin
                     base_in = {12'h000, pair_hi_ff, pair_lo_ff, 4'h0};
                  end
                  TYPE_LINEAR: begin
                     base_in = {pair_hi_ff, pair_lo_ff, 16'h0000};
                  end
                  TYPE_DATA: begin
                     if (len_ff != '0) begin
                        push                    = 1'b1;
                        push_desc.status        = STATUS_DATA;
                        push_desc.address       = start_addr[31:0];
                        push_desc.length        = 8'(len_ff);
                        push_desc.segment_start =
                           !(next_valid_ff && (next_addr_ff == start_addr));
                        next_addr_in  = start_addr + 33'(len_ff);
                        next_valid_in = 1'b1;
                        wr_commit_in  = wr_spec_ff;
                        wr_spec_in    = wr_spec_ff;
                     end
                  end
                  default: begin
                     base_in = base_ff;
                  end
               endcase
            end
         end else begin
            sum_in = check_sum;
            pos_in = pos_ff + 1'b1;
            if (pos_ff == POS_W'(1)) begin
               offset_in = {req_byte_value, 8'h00};
            end else if (pos_ff == POS_W'(2)) begin
               offset_in = {offset_ff[15:8], req_byte_value};
            end else if (pos_ff == POS_W'(3)) begin
               type_in = req_byte_value;
            end else begin
               if (pos_ff == POS_W'(4)) begin
                  pair_hi_in = req_byte_value;
               end
               if (pos_ff == POS_W'(5)) begin
                  pair_lo_in = req_byte_value;
               end
               if (type_ff == TYPE_DATA) begin
                  ring_wr_en = 1'b1;
                  wr_spec_in = wr_spec_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         len_ff        <= '0;
         offset_ff     <= '0;
         type_ff       <= '0;
         sum_ff        <= '0;
         base_ff       <= '0;
         next_addr_ff  <= '0;
         next_valid_ff <= 1'b0;
         halted_ff     <= 1'b0;
         wr_spec_ff    <= '0;
         wr_commit_ff  <= '0;
      end else begin
         pos_ff        <= pos_in;
         len_ff        <= len_in;
         offset_ff     <= offset_in;
         type_ff       <= type_in;
         sum_ff        <= sum_in;
         base_ff       <= base_in;
         next_addr_ff  <= next_addr_in;
         next_valid_ff <= next_valid_in;
         halted_ff     <= halted_in;
         wr_spec_ff    <= wr_spec_in;
         wr_commit_ff  <= wr_commit_in;
      end
   end

   always_ff @(posedge clock) begin
      pair_hi_ff <= pair_hi_in;
      pair_lo_ff <= pair_lo_in;
   end

endmodule

`default_nettype wire

>>> design/hrb_back.sv
`default_nettype none

module hrb_back import hrb_pkg::*; #(
   parameter int MAX_DATA = MAX_DATA_DEFAULT,
   localparam int RING_AW = $clog2(2 * MAX_DATA)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               ring_wr_en,
   input  wire logic [RING_AW-1:0] ring_wr_addr,
   input  wire logic [7:0]         ring_wr_data,
   output logic [RING_AW:0]        ring_rd_ptr,
   input  wire logic               queue_empty,
   input  wire desc_type           head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [31:0]             rsp_address,
   output logic [7:0]              rsp_data_byte,
   output logic                    rsp_segment_start,
   output logic                    rsp_last
);

   localparam int RING_DEPTH = 2 ** RING_AW;
   localparam int IDX_W = $clog2(MAX_DATA + 1);

   logic [7:0]         ring_mem [RING_DEPTH];
   logic [7:0]         rdata_ff;
   logic [RING_AW:0]   rd_ptr_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               out_valid_ff;
   logic [1:0]         status_ff;
   logic [31:0]        address_ff;
   logic               segment_ff;
   logic               last_ff;

   logic               advance;
   logic               issue;
   logic               head_error;
   logic               head_last;

   assign advance    = !out_valid_ff || !rsp_stall;
   assign issue      = advance && !queue_empty;
   assign head_error = (head.status != STATUS_DATA);
   assign head_last  = head_error || ((8'(idx_ff) + 8'd1) == head.length);
   assign pop        = issue && head_last;

   assign ring_rd_ptr       = rd_ptr_ff;
   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_address       = address_ff;
   assign rsp_data_byte     = (status_ff == STATUS_DATA) ? rdata_ff : 8'h00;
   assign rsp_segment_start = segment_ff;
   assign rsp_last          = last_ff;

   always_ff @(posedge clock) begin
      if (ring_wr_en) begin
         ring_mem[ring_wr_addr] <= ring_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rdata_ff <= ring_mem[rd_ptr_ff[RING_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff    <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            out_valid_ff <= issue;
         end
         if (issue && !head_error) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (pop) begin
            idx_ff <= '0;
         end else if (issue) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         status_ff <= head.status;
         if (head_error) begin
            address_ff <= '0;
            segment_ff <= 1'b0;
         end else begin
            address_ff <= head.address + 32'(idx_ff);
            segment_ff <= head.segment_start && (idx_ff == '0);
         end
         last_ff <= head_last;
      end
   end

endmodule

`default_nettype wire

>>> design/hex_record_to_binary_unit.sv
// Input takes one record byte per cycle unless stalled; a record of N data bytes occupies
// N + 5 inputs. The first result of a verified data record or an error is written to the
// record queue when the checksum or length byte is accepted and is then registered at the
// output; results leave at one byte per cycle unless stalled. Input stalls only while the
// data byte ring or the four-entry record queue is full. Synchronous reset clears the parser,
// queue pointers and output valid; the ring memory is not cleared.
`default_nettype none

module hex_record_to_binary_unit import hrb_pkg::*; #(
   parameter int MAX_DATA = MAX_DATA_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_record_start,
   input  wire logic [7:0]  req_byte_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_address,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_segment_start,
   output logic             rsp_last
);

   localparam int RING_AW = $clog2(2 * MAX_DATA);

   logic               ring_wr_en;
   logic [RING_AW-1:0] ring_wr_addr;
   logic [7:0]         ring_wr_data;
   logic [RING_AW:0]   ring_rd_ptr;
   logic               push;
   desc_type           push_desc;
   logic               queue_full;
   logic               queue_empty;
   logic               pop;
   desc_type           head;

   hrb_front #(.MAX_DATA(MAX_DATA)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_record_start (req_record_start),
      .req_byte_value   (req_byte_value),
      .ring_wr_en       (ring_wr_en),
      .ring_wr_addr     (ring_wr_addr),
      .ring_wr_data     (ring_wr_data),
      .ring_rd_ptr      (ring_rd_ptr),
      .push             (push),
      .push_desc        (push_desc),
      .queue_full       (queue_full)
   );

   hrb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .head      (head)
   );

   hrb_back #(.MAX_DATA(MAX_DATA)) u_back (
      .clock             (clock),
      .reset             (reset),
      .ring_wr_en        (ring_wr_en),
      .ring_wr_addr      (ring_wr_addr),
      .ring_wr_data      (ring_wr_data),
      .ring_rd_ptr       (ring_rd_ptr),
      .queue_empty       (queue_empty),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_address       (rsp_address),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_segment_start (rsp_segment_start),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

>>> bench/hex_record_to_binary_unit_checker.sv
`timescale 1ns / 100ps

module hex_record_to_binary_unit_checker import hrb_pkg::*; #(
   parameter int BUFFER_BYTES = MAX_DATA_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_record_start,
   input  logic [7:0]  req_byte_value,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [31:0] rsp_address,
   input  logic [7:0]  rsp_data_byte,
   input  logic        rsp_segment_start,
   input  logic        rsp_last,
   output int          fail_count,
   output int          waiting_results
);

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] address;
      logic [7:0]  data_byte;
      logic        segment_start;
      logic        last;
   } image_byte_type;

   image_byte_type expected_image[$];
   int          mismatches = 0;

   int          field_pos;
   logic [7:0]  rec_len;
   logic [15:0] rec_offset;
   logic [7:0]  rec_type;
   logic [7:0]  sum8;
   logic [7:0]  payload_copy [BUFFER_BYTES];
   logic [31:0] base;
   logic [32:0] next_addr;
   logic        next_ok;
   logic        stopped;

   task automatic flag_error(input logic [1:0] code);
      image_byte_type err;
      stopped = 1'b1;
      field_pos = 0;
      err.status = code;
      err.address = '0;
      err.data_byte = '0;
      err.segment_start = 1'b0;
      err.last = 1'b1;
      expected_image.push_back(err);
   endtask

   task automatic commit_record();
      logic [15:0] pair;
      logic [32:0] start_addr;
      image_byte_type item;
      pair = {(rec_len > 0) ? payload_copy[0] : 8'h00,
              (rec_len > 1) ? payload_copy[1] : 8'h00};
      if (rec_type == TYPE_SEGMENT) begin
         base = {12'h000, pair, 4'h0};
      end else if (rec_type == TYPE_LINEAR) begin
         base = {pair, 16'h0000};
      end else if (rec_type == TYPE_DATA && rec_len > 0) begin
         start_addr = {1'b0, base} + {17'h00000, rec_offset};
         for (int i = 0; i < rec_len; i++) begin
            item.status = STATUS_DATA;
            item.address = start_addr[31:0] + 32'(i);
            item.data_byte = payload_copy[i];
            item.segment_start = (i == 0) && !(next_ok && next_addr == start_addr);
            item.last = (i + 1 == rec_len);
            expected_image.push_back(item);
         end
         next_addr = start_addr + {25'h0, rec_len};
         next_ok = 1'b1;
      end
   endtask

   task automatic decode_record_byte(input logic first, input logic [7:0] value);
      int pos;
      pos = field_pos;
      if (stopped) begin
      end else if (first) begin
         if (value > BUFFER_BYTES) begin
            flag_error(STATUS_LENGTH);
         end else begin
            rec_len = value;
            sum8 = value;
            rec_offset = '0;
            rec_type = '0;
            field_pos = 1;
         end
      end else if (pos == 0) begin
      end else if (pos == 4 + rec_len) begin
         field_pos = 0;
         if (8'(sum8 + value) != 8'h00) begin
            flag_error(STATUS_CHECKSUM);
         end else begin
            commit_record();
         end
      end else begin
         sum8 = 8'(sum8 + value);
         if (pos == 1) begin
            rec_offset = {value, 8'h00};
         end else if (pos == 2) begin
            rec_offset[7:0] = value;
         end else if (pos == 3) begin
            rec_type = value;
         end else if (pos - 4 < BUFFER_BYTES) begin
            payload_copy[pos - 4] = value;
         end
         field_pos = pos + 1;
      end
   endtask

   always @(posedge clock) begin
      image_byte_type seen;
      image_byte_type want;
      if (reset) begin
         field_pos = 0;
         rec_len = '0;
         rec_offset = '0;
         rec_type = '0;
         sum8 = '0;
         base = '0;
         next_addr = '0;
         next_ok = 1'b0;
         stopped = 1'b0;
         expected_image.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.status = rsp_status;
            seen.address = rsp_address;
            seen.data_byte = rsp_data_byte;
            seen.segment_start = rsp_segment_start;
            seen.last = rsp_last;
            if (expected_image.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected status %0d address %h data %h seg %b last %b",
                           $time, seen.status, seen.address, seen.data_byte,
                           seen.segment_start, seen.last);
            end else begin
               want = expected_image.pop_front();
               if (seen.status !== want.status || seen.address !== want.address ||
                   seen.data_byte !== want.data_byte ||
                   seen.segment_start !== want.segment_start || seen.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: expected status %0d address %h data %h seg %b last %b",
                              $time, want.status, want.address, want.data_byte,
                              want.segment_start, want.last);
                     $display("%0t: got status %0d address %h data %h seg %b last %b",
                              $time, seen.status, seen.address, seen.data_byte,
                              seen.segment_start, seen.last);
                  end
               end
            end
         end
         if (req_valid && !req_stall)
            decode_record_byte(req_record_start, req_byte_value);
      end
      fail_count <= mismatches;
      waiting_results <= expected_image.size();
   end

endmodule

>>> bench/hex_record_to_binary_unit_tb.sv
`timescale 1ns / 100ps

module hex_record_to_binary_unit_tb import hrb_pkg::*; ();

   localparam int IDLE_LIMIT = 2000;
   localparam int TARGET_BYTES = 500;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_record_start = 1'b0;
   logic [7:0]  req_byte_value = 8'h00;
   logic        rsp_stall = 1'b0;
   wire         req_stall;
   wire         rsp_valid;
   wire  [1:0]  rsp_status;
   wire  [31:0] rsp_address;
   wire  [7:0]  rsp_data_byte;
   wire         rsp_segment_start;
   wire         rsp_last;

   int          fail_count;
   int          waiting_results;
   logic        send_quiet = 1'b0;
   logic        stall_quiet = 1'b0;
   int          stall_left = 0;
   int          idle_cycles = 0;
   int          record_bytes_sent = 0;
   logic [15:0] follow_offset = 16'h0000;

   hex_record_to_binary_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_record_start  (req_record_start),
      .req_byte_value    (req_byte_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_address       (rsp_address),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_segment_start (rsp_segment_start),
      .rsp_last          (rsp_last)
   );

   hex_record_to_binary_unit_checker image_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_record_start  (req_record_start),
      .req_byte_value    (req_byte_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_address       (rsp_address),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_segment_start (rsp_segment_start),
      .rsp_last          (rsp_last),
      .fail_count        (fail_count),
      .waiting_results   (waiting_results)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int idle_length();
      if ($urandom_range(0, 9) < 8)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (stall_left > 1) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!stall_quiet && $urandom_range(0, 99) < 30) begin
         stall_left <= idle_length();
         rsp_stall <= 1'b1;
      end else begin
         stall_left <= 0;
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("** hex_record_to_binary_unit: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic put_byte(input logic first, input logic [7:0] value);
      if (!send_quiet && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         repeat (idle_length()) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_record_start <= first;
      req_byte_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Style 1 fills the data with 0xFF, style 2 with zeros, anything else with random bytes.
   // A cut of zero or more sends only the bytes up to that index, dropping the checksum.
   task automatic send_record(input logic [7:0] kind, input int count, input logic [15:0] offset,
                              input int style, input int cut, input logic [7:0] skew);
      logic [7:0] rec[$];
      logic [7:0] total;
      rec.push_back(8'(count));
      rec.push_back(offset[15:8]);
      rec.push_back(offset[7:0]);
      rec.push_back(kind);
      for (int k = 0; k < count; k++)
         rec.push_back(style == 1 ? 8'hFF : style == 2 ? 8'h00 : 8'($urandom));
      total = 8'h00;
      for (int k = 0; k < rec.size(); k++)
         total = total + rec[k];
      rec.push_back(8'h00 - total + skew);
      for (int k = 0; k < rec.size() && (cut < 0 || k <= cut); k++) begin
         put_byte(k == 0, rec[k]);
         record_bytes_sent++;
      end
      if (kind == TYPE_DATA && cut < 0)
         follow_offset = offset + 16'(count);
   endtask

   initial begin
      int          records_done;
      int          pick;
      int          count;
      int          style;
      int          cut;
      logic [7:0]  kind;
      logic [15:0] offset;
      logic        drained;
      records_done = 0;
      drained = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_record(TYPE_DATA, 1, 16'hFFFF, 1, -1, 8'h00);
      put_byte(1'b0, 8'hA5);
      send_record(TYPE_LINEAR, 2, 16'h0000, 1, -1, 8'h00);
      send_record(TYPE_DATA, 2, 16'hFFFF, 0, -1, 8'h00);
      send_record(TYPE_DATA, 3, 16'h1234, 0, 1, 8'h00);
      send_record(TYPE_DATA, 0, 16'h0000, 0, -1, 8'h00);

      while (record_bytes_sent < TARGET_BYTES) begin
         if (records_done % 25 == 0) begin
            send_quiet = ($urandom_range(0, 3) == 0);
            stall_quiet <= ($urandom_range(0, 3) == 0);
         end
         if (!drained && record_bytes_sent >= TARGET_BYTES / 2) begin
            drained = 1'b1;
            req_valid <= 1'b0;
            @(posedge clock);
            while (waiting_results != 0) @(posedge clock);
         end
         pick = $urandom_range(0, 99);
         if (pick < 62)
            kind = TYPE_DATA;
         else if (pick < 74)
            kind = TYPE_SEGMENT;
         else if (pick < 86)
            kind = TYPE_LINEAR;
         else if (pick < 90)
            kind = (pick % 2 == 0) ? 8'h01 : 8'h03;
         else
            kind = 8'($urandom_range(5, 255));
         pick = $urandom_range(0, 99);
         if (kind != TYPE_DATA)
            count = $urandom_range(0, 4);
         else if (pick < 5)
            count = 0;
         else if (pick < 12)
            count = MAX_DATA_DEFAULT;
         else if (pick < 70)
            count = $urandom_range(1, 8);
         else
            count = $urandom_range(9, MAX_DATA_DEFAULT - 1);
         offset = ($urandom_range(0, 1) == 0) ? follow_offset : 16'($urandom);
         pick = $urandom_range(0, 99);
         style = (pick < 15) ? 1 : (pick < 25) ? 2 : 0;
         cut = ($urandom_range(0, 99) < 8) ? $urandom_range(0, 3 + count) : -1;
         send_record(kind, count, offset, style, cut, 8'h00);
         if (cut < 0 && $urandom_range(0, 99) < 6)
            put_byte(1'b0, 8'($urandom));
         records_done++;
      end

      // The block halts on an error until reset, so the one error comes last.
      send_quiet = 1'b0;
      stall_quiet <= 1'b0;
      if ($urandom_range(0, 1) == 0)
         put_byte(1'b1, 8'($urandom_range(MAX_DATA_DEFAULT + 1, 255)));
      else
         send_record(TYPE_DATA, $urandom_range(1, 8), 16'($urandom), 0, -1,
                     8'($urandom_range(1, 255)));
      send_record(TYPE_DATA, 2, follow_offset, 0, -1, 8'h00);
      put_byte(1'b0, 8'($urandom));
      req_valid <= 1'b0;

      @(posedge clock);
      while (waiting_results != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && waiting_results == 0)
         $display("** hex_record_to_binary_unit: PASSED **");
      else
         $display("** hex_record_to_binary_unit: FAILED **");
      $finish;
   end

endmodule
